>>> rtl/core/teq_pkg.sv
// ============================================================================
// teq_pkg: timestamp-ordered event queue shared definitions
// Request codes, status codes, sequencer states and fixed field widths.
// ============================================================================
package teq_pkg;

    localparam int KEY_W        = 64;
    localparam int HANDLE_PORT_W = 16;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_PEEK = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_PLACE,
        S_HEAD,
        S_SHIFT
    } state_t;

endpackage

>>> rtl/core/timestamp_ordered_event_queue.sv
// ============================================================================
// timestamp_ordered_event_queue: sorted-array event queue
// Holds (timestamp, handle) words in one RAM sorted by ascending timestamp.
// ============================================================================
// Usage:
//   Request channel: drive req_type / new_timestamp / new_handle and raise
//   start; the word is taken on a rising edge with start high and busy low.
//   Result channel: done pulses for one cycle with status, head_timestamp,
//   head_handle, occupancy and queue_empty. There is no backpressure; the
//   receiver must take the word in that cycle.
// Sequencing:
//   push into an empty queue, full push, empty pop/peek, unused code:
//   done in the cycle after acceptance.
//   push into a non-empty queue: reads the tail, moves each larger key up
//   one slot walking toward the head, then writes the new word where the
//   walk stops. peek: reads slot 0. pop: reads slot 0, then every entry
//   slides down one slot. The RAM takes one write and one registered
//   read per cycle; a new request is accepted the cycle busy drops, which
//   is the cycle done is shown: one word per result back to back.
// Reset: the entry count goes to zero, the sequencer to idle; occupancy and
//   RAM contents are not cleared. Only slots below the count are ever read.
// Equal timestamps leave in arrival order (insert after every key <= new).
// ============================================================================
module timestamp_ordered_event_queue #(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       req_type,
    input  logic [teq_pkg::KEY_W-1:0]        new_timestamp,
    input  logic [teq_pkg::HANDLE_PORT_W-1:0] new_handle,
    output logic                             done,
    output teq_pkg::status_t                 status,
    output logic [teq_pkg::KEY_W-1:0]        head_timestamp,
    output logic [teq_pkg::HANDLE_PORT_W-1:0] head_handle,
    output logic [$clog2(DEPTH+1)-1:0]       occupancy,
    output logic                             queue_empty
);
    import teq_pkg::*;

    // stored handle bits: the port carries 16, HANDLE_BITS may keep fewer
    localparam int HW = (HANDLE_BITS < HANDLE_PORT_W) ? HANDLE_BITS : HANDLE_PORT_W;
    localparam int EW = KEY_W + HW;             // RAM word: {key, handle}
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // ---------------- state ----------------
    state_t              state_reg, state_next;
    logic [1:0]          req_reg, req_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [HW-1:0]       hnd_reg, hnd_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       pos_reg, pos_next;

    // result registers
    logic                      done_reg, done_next;
    status_t                   status_reg, status_next;
    logic [KEY_W-1:0]          head_ts_reg, head_ts_next;
    logic [HANDLE_PORT_W-1:0]  head_hd_reg, head_hd_next;
    logic [CW-1:0]             occ_reg, occ_next;

    // ---------------- RAM ----------------
    logic [EW-1:0]  store_mem [DEPTH];
    logic [EW-1:0]  rd_word_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [EW-1:0]  mem_wdata;
    logic [AW-1:0]  mem_raddr;

    logic [KEY_W-1:0] rd_key;
    logic [HW-1:0]    rd_hnd;
    logic             accept;

    assign rd_key = rd_word_reg[EW-1:HW];
    assign rd_hnd = rd_word_reg[HW-1:0];
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rd_word_reg <= store_mem[mem_raddr];
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_PUSH)
                    begin
                        if (count_reg != CW'(DEPTH) && count_reg != '0)
                        begin
                            state_next = S_INSERT;
                        end
                    end
                    else if (req_type == REQ_POP || req_type == REQ_PEEK)
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = S_HEAD;
                        end
                    end
                end
            end
            S_INSERT:
            begin
                if (rd_key > key_reg)
                begin
                    if (pos_reg == AW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PLACE:
            begin
                state_next = S_IDLE;
            end
            S_HEAD:
            begin
                if (req_reg == REQ_POP && count_reg != CW'(1))
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                if (!(CW'(pos_reg) < count_reg - 1'b1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- datapath / outputs ----------------
    always_comb
    begin
        req_next     = req_reg;
        key_next     = key_reg;
        hnd_next     = hnd_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        mem_we       = 1'b0;
        mem_waddr    = pos_reg;
        mem_wdata    = rd_word_reg;
        mem_raddr    = pos_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        head_ts_next = head_ts_reg;
        head_hd_next = head_hd_reg;
        occ_next     = occ_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next = req_type;
                    key_next = new_timestamp;
                    hnd_next = new_handle[HW-1:0];
                    // default: immediate result with zero head fields
                    head_ts_next = '0;
                    head_hd_next = '0;
                    occ_next     = count_reg;
                    status_next  = STAT_OK;
                    case (req_type)
                        REQ_PUSH:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = STAT_FULL;
                                done_next   = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = {new_timestamp, new_handle[HW-1:0]};
                                count_next = CW'(1);
                                occ_next   = CW'(1);
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                // start the walk from the tail
                                pos_next  = count_reg[AW-1:0];
                                mem_raddr = count_reg[AW-1:0] - 1'b1;
                            end
                        end
                        REQ_POP, REQ_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_raddr = '0;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_INSERT:
            begin
                // rd_word_reg holds slot pos-1
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                if (rd_key > key_reg)
                begin
                    mem_wdata = rd_word_reg;
                    pos_next  = pos_reg - 1'b1;
                    mem_raddr = pos_reg - AW'(2);
                end
                else
                begin
                    mem_wdata  = {key_reg, hnd_reg};
                    count_next = count_reg + 1'b1;
                    occ_next   = count_reg + 1'b1;
                    done_next  = 1'b1;
                end
            end
            S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = {key_reg, hnd_reg};
                count_next = count_reg + 1'b1;
                occ_next   = count_reg + 1'b1;
                done_next  = 1'b1;
            end
            S_HEAD:
            begin
                head_ts_next = rd_key;
                head_hd_next = HANDLE_PORT_W'(rd_hnd);
                if (req_reg == REQ_POP)
                begin
                    if (count_reg == CW'(1))
                    begin
                        count_next = '0;
                        occ_next   = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        pos_next  = AW'(1);
                        mem_raddr = AW'(1);
                    end
                end
                else
                begin
                    occ_next  = count_reg;
                    done_next = 1'b1;
                end
            end
            S_SHIFT:
            begin
                // rd_word_reg holds slot pos; move it down one
                mem_we    = 1'b1;
                mem_waddr = pos_reg - 1'b1;
                mem_wdata = rd_word_reg;
                if (CW'(pos_reg) < count_reg - 1'b1)
                begin
                    pos_next  = pos_reg + 1'b1;
                    mem_raddr = pos_reg + 1'b1;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    occ_next   = count_reg - 1'b1;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        key_reg     <= key_next;
        hnd_reg     <= hnd_next;
        pos_reg     <= pos_next;
        status_reg  <= status_next;
        head_ts_reg <= head_ts_next;
        head_hd_reg <= head_hd_next;
        occ_reg     <= occ_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign head_timestamp = head_ts_reg;
    assign head_handle    = head_hd_reg;
    assign occupancy      = occ_reg;
    assign queue_empty    = (occ_reg == '0);

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: timestamp-ordered event queue check
// Sends push, pop, peek and unused-code words through the start/busy port
// and checks every done word against a sorted-array mirror of the queue.
// A short table covers the corners first. The random traffic that follows
// swings the occupancy between empty and full.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import teq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int HANDLE_BITS = 16;
    localparam int OCC_W       = $clog2(DEPTH + 1);

    // Code 3 is not a request kind. The block must answer it as a no-op.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 1800;
    localparam int DIRECTED_ROWS = 24;
    localparam int REPORT_LIMIT = 10;
    // Longest requests are a pop of a full queue and a push that goes in
    // front of everything. The drain wait allows plenty beyond that.
    localparam int DRAIN_CYCLES = 4 * (DEPTH + 2);

    // One done word as seen on the result ports.
    typedef struct {
        status_t           status;
        logic [KEY_W-1:0]  stamp;
        logic [15:0]       handle;
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
    } queue_reply_t;

    // One directed row. When typed is set, the hand-written reply is the
    // expectation. Otherwise the mirror supplies it.
    typedef struct {
        logic [1:0]        req;
        logic [KEY_W-1:0]  stamp;
        logic [15:0]       handle;
        bit                typed;
        queue_reply_t      want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [1:0]        req_type = REQ_PUSH;
    logic [KEY_W-1:0]  new_timestamp = '0;
    logic [15:0]       new_handle = '0;
    logic              busy;
    logic              done;
    status_t           status;
    logic [KEY_W-1:0]  head_timestamp;
    logic [15:0]       head_handle;
    logic [OCC_W-1:0]  occupancy;
    logic              queue_empty;

    // Mirror of the queue contents, kept sorted like the RAM inside the block.
    logic [KEY_W-1:0]  key_mirror [DEPTH];
    logic [15:0]       handle_mirror [DEPTH];
    int                mirror_count = 0;

    // Replies still owed by the block, oldest first.
    queue_reply_t      reply_q [$];
    int                fail_count = 0;
    int                idle_pct = 26;

    timestamp_ordered_event_queue #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .new_timestamp  (new_timestamp),
        .new_handle     (new_handle),
        .done           (done),
        .status         (status),
        .head_timestamp (head_timestamp),
        .head_handle    (head_handle),
        .occupancy      (occupancy),
        .queue_empty    (queue_empty)
    );

    always #5 clk = ~clk;

    // Hard stop. This is far beyond the slowest legal run: about 1830 words,
    // each no longer than a full-queue pop plus a short random gap.
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Apply one accepted request to the mirror and return the reply it owes.
    // A push goes after every key <= its own, so equal stamps keep arrival
    // order. A push into a full queue, a pop or peek of an empty queue, and
    // the unused code all leave the contents alone.
    function automatic queue_reply_t apply_request(input logic [1:0] req,
                                                   input logic [KEY_W-1:0] stamp,
                                                   input logic [15:0] handle);
        queue_reply_t r;
        int           slot;
        r = '{STAT_OK, '0, '0, '0, 1'b0};
        case (req)
            REQ_PUSH:
            begin
                if (mirror_count >= DEPTH)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    slot = mirror_count;
                    while (slot > 0 && key_mirror[slot-1] > stamp)
                    begin
                        key_mirror[slot]    = key_mirror[slot-1];
                        handle_mirror[slot] = handle_mirror[slot-1];
                        slot--;
                    end
                    key_mirror[slot]    = stamp;
                    handle_mirror[slot] = handle;
                    mirror_count++;
                end
            end
            REQ_POP, REQ_PEEK:
            begin
                if (mirror_count == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    r.stamp  = key_mirror[0];
                    r.handle = handle_mirror[0];
                    if (req == REQ_POP)
                    begin
                        for (int i = 1; i < mirror_count; i++)
                        begin
                            key_mirror[i-1]    = key_mirror[i];
                            handle_mirror[i-1] = handle_mirror[i];
                        end
                        mirror_count--;
                    end
                end
            end
            default: ;
        endcase
        r.occupancy = OCC_W'(mirror_count);
        r.is_empty  = (mirror_count == 0);
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    // Present one word, hold it until the block takes it, then log what it owes.
    // We return in the timestep of the accepting edge, so the caller's next
    // drive is the only one that lands in that step.
    task automatic send_word(input logic [1:0] req, input logic [KEY_W-1:0] stamp,
                             input logic [15:0] handle, input bit typed,
                             input queue_reply_t want);
        queue_reply_t r;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        req_type      <= req;
        new_timestamp <= stamp;
        new_handle    <= handle;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // The mirror must advance even when the row types its own reply.
        r = apply_request(req, stamp, handle);
        reply_q.push_back(typed ? want : r);
    endtask

    // Drop start and hold off until every owed reply has come back.
    task automatic wait_for_quiet();
        start <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
    endtask

    // Mostly small stamps so that equal keys turn up often. Extremes and
    // full-width values come in too, so that every bit toggles.
    function automatic logic [KEY_W-1:0] pick_stamp();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return {$urandom, $urandom};
            4:       return {$urandom, 32'(0)} | KEY_W'($urandom_range(7));
            default: return KEY_W'($urandom_range(40));
        endcase
    endfunction

    // Result side: a reply is valid for exactly the cycle done is high, and
    // it is sampled at the edge that ends that cycle.
    always @(posedge clk)
    begin
        queue_reply_t want;
        if (rst_n && done)
        begin
            if (reply_q.size() == 0)
            begin
                note_failure($sformatf(
                    "done with nothing owed: status=%0d ts=%h hd=%h occ=%0d",
                    status, head_timestamp, head_handle, occupancy));
            end
            else
            begin
                want = reply_q.pop_front();
                if (status !== want.status || head_timestamp !== want.stamp ||
                    head_handle !== want.handle || occupancy !== want.occupancy ||
                    queue_empty !== want.is_empty)
                begin
                    note_failure($sformatf({"exp st=%0d ts=%h hd=%h occ=%0d emp=%0b",
                                            " / got st=%0d ts=%h hd=%h occ=%0d emp=%0b"},
                        want.status, want.stamp, want.handle, want.occupancy, want.is_empty,
                        status, head_timestamp, head_handle, occupancy, queue_empty));
                end
            end
        end
    end

    initial
    begin
        stim_row_t    rows [DIRECTED_ROWS];
        queue_reply_t none;
        logic [1:0]   req;
        bit           filling;
        int           phase_left;
        int           roll;
        int           waited;

        none = '{STAT_OK, '0, '0, '0, 1'b0};
        // Corner table. The stamp and handle on pop, peek and unused rows are
        // junk the block must ignore.
        rows = '{
            // Empty queue right after reset.
            '{REQ_POP,    64'hDEAD_BEEF_0BAD_F00D, 16'hABCD, 1'b1,
              '{STAT_EMPTY, '0, '0, 5'd0, 1'b1}},
            '{REQ_PEEK,   64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1,
              '{STAT_EMPTY, '0, '0, 5'd0, 1'b1}},
            '{REQ_UNUSED, 64'h1234_5678_9ABC_DEF0, 16'h5A5A, 1'b1,
              '{STAT_OK, '0, '0, 5'd0, 1'b1}},
            // Largest key first, then two zero keys that must keep arrival order.
            '{REQ_PUSH,   64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1,
              '{STAT_OK, '0, '0, 5'd1, 1'b0}},
            '{REQ_PUSH,   64'h0,                   16'h0000, 1'b1,
              '{STAT_OK, '0, '0, 5'd2, 1'b0}},
            '{REQ_PUSH,   64'h0,                   16'h0001, 1'b1,
              '{STAT_OK, '0, '0, 5'd3, 1'b0}},
            '{REQ_PEEK,   64'h0,                   16'h0000, 1'b1,
              '{STAT_OK, 64'h0, 16'h0000, 5'd3, 1'b0}},
            // Fill to the brim. The mirror places these.
            '{REQ_PUSH,   64'h8000_0000_0000_0000, 16'h1111, 1'b0, none},
            '{REQ_PUSH,   64'h0000_0000_0000_0001, 16'h2222, 1'b0, none},
            '{REQ_PUSH,   64'h7FFF_FFFF_FFFF_FFFF, 16'h3333, 1'b0, none},
            '{REQ_PUSH,   64'hFFFF_FFFF_FFFF_FFFE, 16'h4444, 1'b0, none},
            '{REQ_PUSH,   64'h0000_0000_0000_0001, 16'h5555, 1'b0, none},
            '{REQ_PUSH,   64'h0000_0001_0000_0000, 16'h6666, 1'b0, none},
            '{REQ_PUSH,   64'hFFFF_FFFF_FFFF_FFFF, 16'h7777, 1'b0, none},
            '{REQ_PUSH,   64'h5555_5555_5555_5555, 16'h8888, 1'b0, none},
            '{REQ_PUSH,   64'hAAAA_AAAA_AAAA_AAAA, 16'h9999, 1'b0, none},
            '{REQ_PUSH,   64'h0123_4567_89AB_CDEF, 16'hAAAA, 1'b0, none},
            '{REQ_PUSH,   64'h0,                   16'hBBBB, 1'b0, none},
            '{REQ_PUSH,   64'h0000_0000_0000_0002, 16'hCCCC, 1'b0, none},
            '{REQ_PUSH,   64'hFEDC_BA98_7654_3210, 16'hDDDD, 1'b0, none},
            // Full: a push bounces, the unused code is still a no-op.
            '{REQ_PUSH,   64'h0,                   16'hEEEE, 1'b1,
              '{STAT_FULL, '0, '0, 5'd16, 1'b0}},
            '{REQ_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1,
              '{STAT_OK, '0, '0, 5'd16, 1'b0}},
            // Head leaves first, and its equal-key twin moves up.
            '{REQ_POP,    64'h0,                   16'h0000, 1'b1,
              '{STAT_OK, 64'h0, 16'h0000, 5'd15, 1'b0}},
            '{REQ_PEEK,   64'h0,                   16'h0000, 1'b1,
              '{STAT_OK, 64'h0, 16'h0001, 5'd15, 1'b0}}
        };

        // Reset is held from time zero and released on an edge.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_word(rows[i].req, rows[i].stamp, rows[i].handle, rows[i].typed,
                      rows[i].want);
        wait_for_quiet();

        // Random traffic alternates between filling and draining runs, so the
        // occupancy keeps sweeping through full and empty.
        filling    = 1'b0;
        phase_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // A stretch with no gaps on the request side, then a full quiet point.
            idle_pct = (n >= 700 && n < 1000) ? 0 : 26;
            if (n == 1000)
                wait_for_quiet();
            if (phase_left == 0)
            begin
                filling    = ~filling;
                phase_left = $urandom_range(80, 20);
            end
            phase_left--;
            roll = $urandom_range(99);
            if (roll < 3)
                req = REQ_UNUSED;
            else if (roll < (filling ? 63 : 33))
                req = REQ_PUSH;
            else if (roll < (filling ? 85 : 83))
                req = REQ_POP;
            else
                req = REQ_PEEK;
            send_word(req, pick_stamp(), 16'($urandom_range(16'hFFFF)), 1'b0, none);
        end

        start  <= 1'b0;
        waited = 0;
        while (reply_q.size() != 0 && waited < 100 * DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        // Let any stray done word show itself.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (reply_q.size() != 0)
            note_failure($sformatf("%0d replies never arrived", reply_q.size()));

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/teq_pkg.sv
rtl/core/timestamp_ordered_event_queue.sv
dv/testbench.sv
